// ===== hw/rtl/mspq_pkg.sv =====
// Package for the multilevel sweep priority queue.
// Holds field widths, register indexes, status codes, state types and helpers.
// Used by mspq_level_calc and multilevel_sweep_priority_queue.
package mspq_pkg;

   localparam int NUM_LEVELS_DEF  = 100;
   localparam int NUM_HANDLES_DEF = 1024;

   localparam int HANDLE_W    = 10;
   localparam int PRIO_W      = 8;
   localparam int CARDS_W     = 6;
   localparam int STATUS_W    = 2;
   localparam int OUT_LEVEL_W = 7;
   localparam int OP_W        = 1;
   localparam int COEF_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int ACC_W       = 48;
   localparam int MUL_B_W     = 14;

   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_STACK_MODE  = 2'd0;
   localparam logic [1:0] REG_COEF_SQUARE = 2'd1;
   localparam logic [1:0] REG_COEF_LINEAR = 2'd2;
   localparam logic [1:0] REG_COEF_CONST  = 2'd3;

   localparam logic signed [COEF_W-1:0] COEF_SQUARE_RST = -32'sd52;
   localparam logic signed [COEF_W-1:0] COEF_LINEAR_RST = 32'sd9175;
   localparam logic signed [COEF_W-1:0] COEF_CONST_RST  = -32'sd65536;

   localparam logic [0:0] OP_ENQUEUE = 1'b0;
   localparam logic [0:0] OP_DEQUEUE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ENQUEUED = 2'd0,
      STATUS_DEQUEUED = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] square;
      logic signed [COEF_W-1:0] linear;
      logic signed [COEF_W-1:0] konst;
   } coef_type;

   typedef enum logic [2:0] {
      LC_IDLE,
      LC_SQUARE,
      LC_MUL_SQ,
      LC_MUL_LIN,
      LC_SUM,
      LC_CLAMP
   } lc_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_ENQ_RD,
      ST_ENQ_WR,
      ST_SCAN,
      ST_POP_RD,
      ST_POP_LINK,
      ST_POP_WR,
      ST_LOWER,
      ST_DONE
   } state_type;

   // Handle modulo the link table depth. The quotient comes from a constant
   // reciprocal scaled by 2^(2*HANDLE_W), which is exact for every handle that
   // fits in HANDLE_W bits; the remainder is one multiply and subtract away.
   function automatic logic [HANDLE_W-1:0] handle_mod(input logic [HANDLE_W-1:0] h,
                                                      input int unsigned nh);
      longint unsigned recip;
      longint unsigned quot;
      longint unsigned r;
      recip = ((64'd1 << (2 * HANDLE_W)) + 64'(nh) - 64'd1) / 64'(nh);
      quot  = (64'(h) * recip) >> (2 * HANDLE_W);
      r     = 64'(h) - quot * 64'(nh);
      return r[HANDLE_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/multilevel_sweep_priority_queue.sv =====
// Multilevel sweep priority queue, top level.
// Depends on mspq_pkg and mspq_level_calc.
//
// Usage: each beat on the req channel is one command. tuser carries the opcode
// (enqueue or dequeue); tdata carries the handle, the signed move priority and
// the cards-out count. Each command yields exactly one beat on the rsp channel,
// whose tuser holds the status and whose tdata holds the handle and the level.
// The block works on one command at a time and deasserts req_tready meanwhile.
// An enqueue passes from acceptance to a valid response through the level
// unit, whose single multiplier forms n*n, then the square and linear terms,
// then a memory read, a head, tail or link write and the load of the output
// register; req_tready rises together with rsp_tvalid. A dequeue sweeps down
// over the levels, one level per cycle, reads the head of the level it finds,
// follows its link (writing the new head when the level keeps further
// entries), drops the empty top levels, one per cycle, and loads the output
// register. On an empty queue the highest level has already fallen to zero,
// so the sweep wraps to level zero, finds nothing there and reports it empty.
// Reset empties every level, clears the sweep state and restores the
// coefficient registers; the head, tail and link memories are not cleared,
// as every entry is written before it is read. When the receiver stalls, the
// response waits in the output register and a finished command holds its
// result until that register is free. Registers go on the csr port at 4*index.
module multilevel_sweep_priority_queue #(
   parameter int NUM_LEVELS  = mspq_pkg::NUM_LEVELS_DEF,
   parameter int NUM_HANDLES = mspq_pkg::NUM_HANDLES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Command channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: entry_handle[9:0], move_priority[17:10], cards_out[23:18]
   input  logic [mspq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: op[0]
   input  logic [mspq_pkg::OP_W-1:0]           req_tuser,
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: out_handle[9:0], out_level[16:10], zero[23:17]
   output logic [mspq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: status[1:0]
   output logic [mspq_pkg::STATUS_W-1:0]       rsp_tuser,
   // Register port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mspq_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mspq_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mspq_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import mspq_pkg::*;

   localparam int LVL_W  = $clog2(NUM_LEVELS);
   localparam int SP_W   = LVL_W + 2;
   localparam int HIDX_W = $clog2(NUM_HANDLES);

   // Configuration registers.
   logic                stack_mode_ff;
   coef_type            coef_ff;
   logic                csr_write;

   // Control state.
   state_type                state_ff, state_in;
   logic [NUM_LEVELS-1:0]    nonempty_ff, nonempty_in;
   logic [LVL_W-1:0]         top_ff, top_in;
   logic signed [SP_W-1:0]   scan_ff, scan_in;
   logic signed [SP_W-1:0]   floor_ff, floor_in;
   logic                     last_ff, last_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [HANDLE_W-1:0]      handle_ff, handle_in;
   logic [LVL_W-1:0]         cur_lvl_ff, cur_lvl_in;
   status_type               res_status_ff, res_status_in;
   logic [HANDLE_W-1:0]      res_handle_ff, res_handle_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]      rsp_handle_ff, rsp_handle_in;
   logic [OUT_LEVEL_W-1:0]   rsp_level_ff, rsp_level_in;

   // Level memories and the link memory.
   logic [HANDLE_W-1:0]      head_mem [NUM_LEVELS];
   logic [HANDLE_W-1:0]      tail_mem [NUM_LEVELS];
   logic [HANDLE_W-1:0]      link_mem [NUM_HANDLES];
   logic [HANDLE_W-1:0]      head_rd_ff;
   logic [HANDLE_W-1:0]      tail_rd_ff;
   logic [HANDLE_W-1:0]      link_rd_ff;
   logic                     head_we, tail_we, link_we;
   logic [HANDLE_W-1:0]      head_wdata, tail_wdata, link_wdata;
   logic [HIDX_W-1:0]        link_waddr, link_raddr;

   // Level unit interface.
   logic                     req_accept;
   logic                     lc_start;
   logic                     lc_done;
   logic [LVL_W-1:0]         lc_level;

   // Sweep step temporaries.
   logic signed [SP_W-1:0]   top_s;
   logic signed [SP_W-1:0]   sp;
   logic signed [SP_W-1:0]   fl;
   logic signed [SP_W-1:0]   scan_m1;
   logic                     lst;
   logic                     sweep_empty;
   logic                     sweep_hit;

   //------------------------------------------------------------------
   // Register port. Writes land when psel, penable, pwrite and pready
   // are all high; reads are answered in the same cycle.
   //------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_mode_ff  <= 1'b0;
         coef_ff.square <= COEF_SQUARE_RST;
         coef_ff.linear <= COEF_LINEAR_RST;
         coef_ff.konst  <= COEF_CONST_RST;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_STACK_MODE:  stack_mode_ff  <= csr_pwdata[0];
            REG_COEF_SQUARE: coef_ff.square <= csr_pwdata;
            REG_COEF_LINEAR: coef_ff.linear <= csr_pwdata;
            REG_COEF_CONST:  coef_ff.konst  <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_STACK_MODE:  csr_prdata = {{(CSR_DATA_W-1){1'b0}}, stack_mode_ff};
         REG_COEF_SQUARE: csr_prdata = coef_ff.square;
         REG_COEF_LINEAR: csr_prdata = coef_ff.linear;
         REG_COEF_CONST:  csr_prdata = coef_ff.konst;
         default:         csr_prdata = '0;
      endcase
   end

   //------------------------------------------------------------------
   // Command acceptance and the level unit.
   //------------------------------------------------------------------
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign lc_start   = req_accept && (req_tuser == OP_ENQUEUE);

   mspq_level_calc #(
      .NUM_LEVELS (NUM_LEVELS),
      .LVL_W      (LVL_W)
   ) u_level_calc (
      .clock (clock),
      .reset (reset),
      .start (lc_start),
      .prio  (req_tdata[17:10]),
      .cards (req_tdata[23:18]),
      .coef  (coef_ff),
      .done  (lc_done),
      .level (lc_level)
   );

   //------------------------------------------------------------------
   // Memories. Each is read every cycle at the current address, with
   // the read data registered; writes come from the sequencer.
   //------------------------------------------------------------------
   assign link_raddr = HIDX_W'(handle_mod(head_rd_ff, NUM_HANDLES));

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[cur_lvl_ff] <= head_wdata;
      end
      head_rd_ff <= head_mem[cur_lvl_ff];
   end

   always_ff @(posedge clock) begin
      if (tail_we) begin
         tail_mem[cur_lvl_ff] <= tail_wdata;
      end
      tail_rd_ff <= tail_mem[cur_lvl_ff];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[link_raddr];
   end

   //------------------------------------------------------------------
   // Sequencer state.
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nonempty_ff  <= '0;
         top_ff       <= '0;
         scan_ff      <= '0;
         floor_ff     <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nonempty_ff  <= nonempty_in;
         top_ff       <= top_in;
         scan_ff      <= scan_in;
         floor_ff     <= floor_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff     <= handle_in;
      cur_lvl_ff    <= cur_lvl_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_level_ff  <= rsp_level_in;
   end

   assign top_s = {2'b00, top_ff};

   // One step of the downward sweep. The floor drops by one each time a sweep
   // restarts at the top (below zero it wraps to the top), so sweeps grow longer;
   // once a sweep from the top down to level zero finds nothing, the queue is empty.
   always_comb begin
      sp          = scan_ff - SP_W'(1);
      fl          = floor_ff;
      lst         = last_ff;
      sweep_empty = 1'b0;
      if (sp < floor_ff) begin
         if (last_ff) begin
            sweep_empty = 1'b1;
         end else begin
            sp = top_s;
            fl = floor_ff - SP_W'(1);
            if (fl < 0) begin
               fl = top_s;
            end
            if (fl == 0) begin
               lst = 1'b1;
            end
         end
      end
      sweep_hit = !sweep_empty && (sp >= 0) && (sp < NUM_LEVELS)
                  && nonempty_ff[sp[LVL_W-1:0]];
   end

   assign scan_m1 = scan_ff - SP_W'(1);

   always_comb begin
      state_in      = state_ff;
      nonempty_in   = nonempty_ff;
      top_in        = top_ff;
      scan_in       = scan_ff;
      floor_in      = floor_ff;
      last_in       = last_ff;
      handle_in     = handle_ff;
      cur_lvl_in    = cur_lvl_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      head_we       = 1'b0;
      tail_we       = 1'b0;
      link_we       = 1'b0;
      head_wdata    = handle_ff;
      tail_wdata    = handle_ff;
      link_wdata    = handle_ff;
      link_waddr    = HIDX_W'(handle_mod(handle_ff, NUM_HANDLES));

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               handle_in = req_tdata[HANDLE_W-1:0];
               if (req_tuser == OP_DEQUEUE) begin
                  last_in  = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_LEVEL;
               end
            end
         end

         ST_LEVEL: begin
            if (lc_done) begin
               cur_lvl_in = lc_level;
               if (lc_level > top_ff) begin
                  top_in = lc_level;
               end
               state_in = ST_ENQ_RD;
            end
         end

         ST_ENQ_RD: begin
            state_in = ST_ENQ_WR;
         end

         ST_ENQ_WR: begin
            if (!nonempty_ff[cur_lvl_ff]) begin
               head_we                 = 1'b1;
               tail_we                 = 1'b1;
               nonempty_in[cur_lvl_ff] = 1'b1;
            end else if (stack_mode_ff) begin
               // Push at the head: the new entry links to the old head.
               link_we    = 1'b1;
               link_wdata = head_rd_ff;
               head_we    = 1'b1;
            end else begin
               // Append at the tail: the old tail links to the new entry.
               link_we    = 1'b1;
               link_waddr = HIDX_W'(handle_mod(tail_rd_ff, NUM_HANDLES));
               tail_we    = 1'b1;
            end
            res_status_in = STATUS_ENQUEUED;
            res_handle_in = handle_ff;
            state_in      = ST_DONE;
         end

         ST_SCAN: begin
            scan_in  = sp;
            floor_in = fl;
            last_in  = lst;
            if (sweep_empty) begin
               res_status_in = STATUS_EMPTY;
               res_handle_in = '0;
               cur_lvl_in    = '0;
               state_in      = ST_DONE;
            end else if (sweep_hit) begin
               cur_lvl_in = sp[LVL_W-1:0];
               state_in   = ST_POP_RD;
            end
         end

         ST_POP_RD: begin
            state_in = ST_POP_LINK;
         end

         ST_POP_LINK: begin
            res_status_in = STATUS_DEQUEUED;
            res_handle_in = head_rd_ff;
            if (head_rd_ff == tail_rd_ff) begin
               // Last entry of the level: the level becomes empty.
               nonempty_in[cur_lvl_ff] = 1'b0;
               state_in                = ST_LOWER;
            end else begin
               state_in = ST_POP_WR;
            end
         end

         ST_POP_WR: begin
            head_we    = 1'b1;
            head_wdata = link_rd_ff;
            state_in   = ST_LOWER;
         end

         ST_LOWER: begin
            // Drop the highest level while it is empty, one level a cycle.
            if ((scan_ff == top_s) && (top_ff != '0)
                && !nonempty_ff[scan_ff[LVL_W-1:0]]) begin
               top_in  = top_ff - LVL_W'(1);
               scan_in = scan_m1;
               if (scan_m1 < floor_ff) begin
                  floor_in = scan_m1;
               end
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_handle_in = res_handle_ff;
               rsp_level_in  = OUT_LEVEL_W'(cur_lvl_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   //------------------------------------------------------------------
   // Response channel.
   //------------------------------------------------------------------
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-OUT_LEVEL_W-HANDLE_W){1'b0}}, rsp_level_ff,
                        rsp_handle_ff};

endmodule

// ===== hw/rtl/mspq_level_calc.sv =====
// Level calculation unit: rounded Q16 quadratic bonus plus priority, clamped.
// One shared multiplier forms n*n and then the square and linear terms. Depends on mspq_pkg.
module mspq_level_calc #(
   parameter int NUM_LEVELS = mspq_pkg::NUM_LEVELS_DEF,
   parameter int LVL_W      = $clog2(NUM_LEVELS)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [mspq_pkg::PRIO_W-1:0]  prio,
   input  logic [mspq_pkg::CARDS_W-1:0]        cards,
   input  mspq_pkg::coef_type                  coef,
   output logic                                done,
   output logic [LVL_W-1:0]                    level
);
   import mspq_pkg::*;

   lc_state_type               state_ff, state_in;
   logic signed [PRIO_W-1:0]   prio_ff, prio_in;
   logic [CARDS_W-1:0]         cards_ff, cards_in;
   logic signed [ACC_W-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [COEF_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [ACC_W-1:0]    prio_ext;
   logic signed [ACC_W-1:0]    sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff  <= prio_in;
      cards_ff <= cards_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
   end

   // The shared multiplier: product is registered before it is summed.
   assign prod_in = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      prio_in  = prio_ff;
      cards_in = cards_ff;
      acc_in   = acc_ff;
      mul_a    = {{(COEF_W-CARDS_W){1'b0}}, cards_ff};
      mul_b    = {{(MUL_B_W-CARDS_W){1'b0}}, cards_ff};
      case (state_ff)
         LC_IDLE: begin
            if (start) begin
               prio_in  = prio;
               cards_in = cards;
               state_in = LC_SQUARE;
            end
         end
         LC_SQUARE: begin
            state_in = LC_MUL_SQ;
         end
         LC_MUL_SQ: begin
            mul_a    = coef.square;
            mul_b    = {{(MUL_B_W-2*CARDS_W){1'b0}}, prod_ff[2*CARDS_W-1:0]};
            acc_in   = {{(ACC_W-COEF_W){coef.konst[COEF_W-1]}}, coef.konst}
                       + (ACC_W'(1) <<< (FRAC_W - 1));
            state_in = LC_MUL_LIN;
         end
         LC_MUL_LIN: begin
            mul_a    = coef.linear;
            acc_in   = acc_ff + prod_ff;
            state_in = LC_SUM;
         end
         LC_SUM: begin
            acc_in   = acc_ff + prod_ff;
            state_in = LC_CLAMP;
         end
         LC_CLAMP: begin
            state_in = LC_IDLE;
         end
         default: begin
            state_in = LC_IDLE;
         end
      endcase
   end

   assign prio_ext = {{(ACC_W-PRIO_W){prio_ff[PRIO_W-1]}}, prio_ff};
   assign sum      = (acc_ff >>> FRAC_W) + prio_ext;
   assign done     = (state_ff == LC_CLAMP);

   always_comb begin
      if (sum[ACC_W-1]) begin
         level = '0;
      end else if (sum > ACC_W'(NUM_LEVELS - 1)) begin
         level = LVL_W'(NUM_LEVELS - 1);
      end else begin
         level = sum[LVL_W-1:0];
      end
   end

endmodule

// ===== sim/mspq_checker.sv =====
// Checker for the multilevel sweep priority queue: watches the command, response and
// register ports, keeps its own copy of the queue state and compares every response beat.
// Depends on mspq_pkg for field widths, register indexes, opcodes and status codes.
`timescale 1ns / 1ps

module mspq_checker #(
   parameter int NUM_LEVELS  = mspq_pkg::NUM_LEVELS_DEF,
   parameter int NUM_HANDLES = mspq_pkg::NUM_HANDLES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [mspq_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [mspq_pkg::OP_W-1:0]           req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [mspq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic [mspq_pkg::STATUS_W-1:0]       rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mspq_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mspq_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   input  logic [mspq_pkg::CSR_DATA_W-1:0]     csr_prdata,
   input  logic                                csr_pready,
   output int                                  fail_count,
   output int                                  beats_due
);
   import mspq_pkg::*;

   typedef struct packed {
      status_type                status;
      logic [HANDLE_W-1:0]       handle;
      logic [OUT_LEVEL_W-1:0]    level;
   } rsp_beat_type;

   bit                          stack_lifo;
   logic signed [COEF_W-1:0]    coef_sq;
   logic signed [COEF_W-1:0]    coef_lin;
   logic signed [COEF_W-1:0]    coef_k;

   logic [HANDLE_W-1:0]         head_of   [NUM_LEVELS];
   logic [HANDLE_W-1:0]         tail_of   [NUM_LEVELS];
   bit                          occupied  [NUM_LEVELS];
   logic [HANDLE_W-1:0]         successor [NUM_HANDLES];
   int                          highest;
   int                          sweep_pos;
   int                          sweep_low;

   rsp_beat_type                due_beats [$];
   rsp_beat_type                want;
   int                          errors = 0;

   assign fail_count = errors;

   // Level = move priority plus the Q16 quadratic bonus rounded half up, clamped.
   function automatic int placement_level(input logic signed [PRIO_W-1:0] prio,
                                          input logic [CARDS_W-1:0] cards);
      longint n;
      longint acc;
      longint lvl;
      n   = longint'(cards);
      acc = longint'(coef_sq) * n * n + longint'(coef_lin) * n + longint'(coef_k);
      lvl = longint'(prio) + ((acc + 64'sd32768) >>> FRAC_W);
      if (lvl < 0) begin
         lvl = 0;
      end else if (lvl > NUM_LEVELS - 1) begin
         lvl = NUM_LEVELS - 1;
      end
      return int'(lvl);
   endfunction

   function automatic rsp_beat_type file_entry(input logic [HANDLE_W-1:0] h,
                                               input logic signed [PRIO_W-1:0] prio,
                                               input logic [CARDS_W-1:0] cards);
      int           lv;
      rsp_beat_type b;
      lv = placement_level(prio, cards);
      if (lv > highest) begin
         highest = lv;
      end
      if (!occupied[lv]) begin
         head_of[lv]  = h;
         tail_of[lv]  = h;
         occupied[lv] = 1'b1;
      end else if (stack_lifo) begin
         successor[h % NUM_HANDLES] = head_of[lv];
         head_of[lv] = h;
      end else begin
         successor[tail_of[lv] % NUM_HANDLES] = h;
         tail_of[lv] = h;
      end
      b.status = STATUS_ENQUEUED;
      b.handle = h;
      b.level  = OUT_LEVEL_W'(lv);
      return b;
   endfunction

   // Sweeps run down from the highest level to a floor that drops by one on each
   // new sweep; a full set of sweeps ending at level zero with nothing found means
   // the queue is empty.
   function automatic rsp_beat_type take_next();
      bit                  final_sweep;
      int                  lv;
      logic [HANDLE_W-1:0] h;
      rsp_beat_type        b;
      final_sweep = 1'b0;
      b.status = STATUS_EMPTY;
      b.handle = '0;
      b.level  = '0;
      forever begin
         sweep_pos--;
         if (sweep_pos < sweep_low) begin
            if (final_sweep) begin
               return b;
            end
            sweep_pos = highest;
            sweep_low--;
            if (sweep_low < 0) begin
               sweep_low = highest;
            end
            if (sweep_low == 0) begin
               final_sweep = 1'b1;
            end
         end
         if (sweep_pos >= 0 && sweep_pos < NUM_LEVELS && occupied[sweep_pos]) begin
            break;
         end
      end
      lv = sweep_pos;
      h  = head_of[lv];
      if (h == tail_of[lv]) begin
         occupied[lv] = 1'b0;
      end else begin
         head_of[lv] = successor[h % NUM_HANDLES];
      end
      while (!occupied[sweep_pos] && sweep_pos == highest && highest > 0) begin
         highest--;
         sweep_pos--;
         if (sweep_pos < sweep_low) begin
            sweep_low = sweep_pos;
         end
      end
      b.status = STATUS_DEQUEUED;
      b.handle = h;
      b.level  = OUT_LEVEL_W'(lv);
      return b;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] register_value(input logic [1:0] idx);
      case (idx)
         REG_STACK_MODE:  return CSR_DATA_W'(stack_lifo);
         REG_COEF_SQUARE: return coef_sq;
         REG_COEF_LINEAR: return coef_lin;
         default:         return coef_k;
      endcase
   endfunction

   task automatic check_field(input string what, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (actual !== expected) begin
         errors++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, what, expected, actual);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stack_lifo = 1'b0;
         coef_sq    = COEF_SQUARE_RST;
         coef_lin   = COEF_LINEAR_RST;
         coef_k     = COEF_CONST_RST;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            occupied[i] = 1'b0;
         end
         highest   = 0;
         sweep_pos = 0;
         sweep_low = 0;
         due_beats.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[3:2])
                  REG_STACK_MODE:  stack_lifo = csr_pwdata[0];
                  REG_COEF_SQUARE: coef_sq    = csr_pwdata;
                  REG_COEF_LINEAR: coef_lin   = csr_pwdata;
                  default:         coef_k     = csr_pwdata;
               endcase
            end else begin
               check_field("register read", register_value(csr_paddr[3:2]), csr_prdata);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_DEQUEUE) begin
               due_beats.push_back(take_next());
            end else begin
               due_beats.push_back(file_entry(req_tdata[9:0], req_tdata[17:10],
                                              req_tdata[23:18]));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_beats.size() == 0) begin
               errors++;
               $display("%0t: response beat with none due, actual status %0d data 0x%0h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = due_beats.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_tuser));
               check_field("handle", 32'(want.handle), 32'(rsp_tdata[9:0]));
               check_field("level", 32'(want.level), 32'(rsp_tdata[16:10]));
               check_field("tdata padding", 32'd0, 32'(rsp_tdata[23:17]));
            end
         end
      end
      beats_due <= due_beats.size();
   end

endmodule

// ===== sim/tb_multilevel_sweep_priority_queue.sv =====
// Top of the testbench for the multilevel sweep priority queue: clock, reset, command
// and register stimulus, response back-pressure and the final verdict.
// Depends on mspq_pkg, the block itself and mspq_checker, which does all the checking.
`timescale 1ns / 1ps

module tb_multilevel_sweep_priority_queue;
   import mspq_pkg::*;

   // A dequeue sweeps down from the top level to a floor that drops on each new sweep,
   // then drops every empty top level; even with both sides idling the full run
   // stays far below this limit.
   localparam int CYCLE_LIMIT      = 2_000_000;
   localparam int RANDOM_PER_PHASE = 236;
   localparam int NUM_PHASES       = 7;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_W-1:0]     req_tdata   = '0;
   logic [OP_W-1:0]           req_tuser   = OP_ENQUEUE;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]     rsp_tdata;
   logic [STATUS_W-1:0]       rsp_tuser;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]     csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]     csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   int                        fail_count;
   int                        beats_due;

   // Handles currently held in the queue, so that no handle is ever queued twice
   // by the random stimulus (the block assumes this).
   bit                        live_map [NUM_HANDLES_DEF];
   int                        enq_marked = 0;
   int                        enq_sent   = 0;
   int                        deq_sent   = 0;
   int                        deq_done   = 0;
   int                        empty_seen = 0;
   int                        deq_bias   = 45;
   bit                        no_idle    = 1'b0;
   int                        rsp_wait   = 0;
   int                        stall_draw;
   int                        cycles     = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   multilevel_sweep_priority_queue i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mspq_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .beats_due   (beats_due)
   );

   // Response side. After every accepted beat the receiver draws a random stall
   // (or none); during stretches with idling switched off it stays ready. The
   // same block notes which handles have left the queue.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (rsp_tuser == STATUS_DEQUEUED) begin
            live_map[rsp_tdata[HANDLE_W-1:0]] <= 1'b0;
            deq_done <= deq_done + 1;
         end
         if (rsp_tuser == STATUS_EMPTY) begin
            empty_seen <= empty_seen + 1;
         end
         stall_draw = no_idle ? 0 : $urandom_range(0, 5);
         rsp_wait   <= stall_draw;
         rsp_tready <= (stall_draw == 0);
      end else if (rsp_wait > 1) begin
         rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_wait   <= 0;
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_multilevel_sweep_priority_queue: done, errors");
         $finish;
      end
   end

   // One command beat. The data is presented and held until the block takes it;
   // only then is the idle gap before the next beat drawn. With no gap, valid stays
   // high and the next call simply puts new data on the bus, so valid is never
   // lowered and raised in the same time step. The caller lowers valid after the
   // last beat of a run.
   task automatic send_cmd(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h,
                           input logic signed [PRIO_W-1:0] prio,
                           input logic [CARDS_W-1:0] cards);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {cards, prio, h};
      do @(posedge clock); while (!req_tready);
      if (op == OP_ENQUEUE) begin
         enq_sent++;
         if (!live_map[h]) begin
            live_map[h] = 1'b1;
            enq_marked++;
         end
      end else begin
         deq_sent++;
      end
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // One register access. penable is left high at the end; the next access starts
   // its setup cycle by lowering it, and the caller closes the burst.
   task automatic csr_access(input bit wr, input logic [1:0] idx,
                             input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // Writes all four registers, then reads each back so the checker can compare.
   task automatic program_regs(input bit lifo, input logic [CSR_DATA_W-1:0] sq,
                               input logic [CSR_DATA_W-1:0] lin,
                               input logic [CSR_DATA_W-1:0] k);
      logic [1:0]            regs [4];
      logic [CSR_DATA_W-1:0] vals [4];
      regs = '{REG_STACK_MODE, REG_COEF_SQUARE, REG_COEF_LINEAR, REG_COEF_CONST};
      vals = '{CSR_DATA_W'(lifo), sq, lin, k};
      for (int r = 0; r < 4; r++) begin
         csr_access(1'b1, regs[r], vals[r]);
      end
      for (int r = 0; r < 4; r++) begin
         csr_access(1'b0, regs[r], '0);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Waits until every expected response beat has arrived, then waits for as many
   // further clocks as extra gives, so that nothing is still in flight.
   task automatic settle(input int extra);
      do @(posedge clock); while (beats_due != 0);
      repeat (extra) @(posedge clock);
   endtask

   // Random commands. Handles are always fresh, so every sequence is well formed;
   // the dequeue share swings between filling and draining the queue so that it
   // runs empty now and then. Cards-out mostly stays in the deck range but also
   // covers the values above it; priorities mostly land inside the level range.
   task automatic random_cmds(input int count);
      int                         held;
      bit                         pop;
      logic [HANDLE_W-1:0]        h;
      logic signed [PRIO_W-1:0]   prio;
      logic [CARDS_W-1:0]         cards;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            no_idle  = ($urandom_range(0, 3) == 0);
            deq_bias = $urandom_range(0, 1) ? 65 : 35;
         end
         held = enq_marked - deq_done;
         if (held <= 0) begin
            pop = ($urandom_range(0, 3) == 0);
         end else if (held > 600) begin
            pop = 1'b1;
         end else begin
            pop = ($urandom_range(0, 99) < deq_bias);
         end
         if ($urandom_range(0, 6) == 0) begin
            cards = CARDS_W'($urandom_range(53, 63));
         end else begin
            cards = CARDS_W'($urandom_range(0, 52));
         end
         if ($urandom_range(0, 3) == 0) begin
            prio = PRIO_W'($urandom);
         end else begin
            prio = PRIO_W'($urandom_range(0, 99));
         end
         if (pop) begin
            // The handle field is ignored on a dequeue; random bits go there anyway.
            send_cmd(OP_DEQUEUE, HANDLE_W'($urandom), prio, cards);
         end else begin
            do h = HANDLE_W'($urandom); while (live_map[h]);
            send_cmd(OP_ENQUEUE, h, prio, cards);
         end
      end
   endtask

   initial begin
      logic signed [CSR_DATA_W-1:0] sq;
      logic signed [CSR_DATA_W-1:0] lin;
      logic signed [CSR_DATA_W-1:0] k;
      bit                           lifo;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset coefficients, FIFO order. First a dequeue on
      // an empty queue, then a handle queued twice into an empty level: its second
      // copy links the handle to itself, and the single pop empties the level.
      send_cmd(OP_DEQUEUE, '0, '0, '0);
      send_cmd(OP_ENQUEUE, 10'd5, 8'sd10, 6'd0);
      send_cmd(OP_ENQUEUE, 10'd5, 8'sd10, 6'd0);
      send_cmd(OP_DEQUEUE, '0, '0, '0);
      send_cmd(OP_DEQUEUE, '1, '0, '0);
      // Field extremes: lowest priority clamps to level zero, highest priority with
      // cards-out beyond the deck clamps to the top level. Two entries share one
      // level to show FIFO order, and the level then ends after its last entry.
      send_cmd(OP_ENQUEUE, 10'd0, -8'sd128, 6'd0);
      send_cmd(OP_ENQUEUE, 10'd1023, 8'sd127, 6'd63);
      send_cmd(OP_ENQUEUE, 10'd512, 8'sd40, 6'd52);
      send_cmd(OP_ENQUEUE, 10'd513, 8'sd40, 6'd52);
      send_cmd(OP_ENQUEUE, 10'd300, 8'sd20, 6'd26);
      send_cmd(OP_ENQUEUE, 10'd301, 8'sd0, 6'd10);
      send_cmd(OP_ENQUEUE, 10'd777, 8'sd50, 6'd57);
      repeat (8) begin
         send_cmd(OP_DEQUEUE, HANDLE_W'($urandom), '0, '0);
      end
      random_cmds(RANDOM_PER_PHASE);
      req_tvalid <= 1'b0;

      // Later phases reprogram the registers while the block is idle: stack order
      // with the reset coefficients, all-zero coefficients, both sets of extremes,
      // small random coefficients that spread entries over the levels, and fully
      // random ones.
      for (int phase = 1; phase < NUM_PHASES; phase++) begin
         settle(16);
         case (phase)
            1: begin
               lifo = 1'b1; sq = COEF_SQUARE_RST; lin = COEF_LINEAR_RST; k = COEF_CONST_RST;
            end
            2: begin
               lifo = 1'b0; sq = '0; lin = '0; k = '0;
            end
            3: begin
               lifo = 1'b1; sq = 32'h7FFF_FFFF; lin = 32'h8000_0000; k = 32'h7FFF_FFFF;
            end
            4: begin
               lifo = 1'b0; sq = 32'h8000_0000; lin = 32'h7FFF_FFFF; k = 32'h8000_0000;
            end
            5: begin
               lifo = 1'($urandom_range(0, 1));
               sq   = int'($urandom_range(0, 8191)) - 4096;
               lin  = int'($urandom_range(0, 262143)) - 131072;
               k    = int'($urandom_range(0, 6553600)) - 3276800;
            end
            default: begin
               lifo = 1'($urandom_range(0, 1)); sq = $urandom; lin = $urandom; k = $urandom;
            end
         endcase
         program_regs(lifo, sq, lin, k);
         random_cmds(RANDOM_PER_PHASE);
         req_tvalid <= 1'b0;
      end

      settle(64);
      $display("Run covered %0d command beats: %0d enqueues, %0d dequeues, %0d empty.",
               enq_sent + deq_sent, enq_sent, deq_sent, empty_seen);
      $display("Settings: %0d phases, FIFO and LIFO, reset, zero, extreme, random coefs.",
               NUM_PHASES);
      if (fail_count == 0) begin
         $display("tb_multilevel_sweep_priority_queue: done, clean");
      end else begin
         $display("tb_multilevel_sweep_priority_queue: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/mspq_pkg.sv
hw/rtl/mspq_level_calc.sv
hw/rtl/multilevel_sweep_priority_queue.sv
sim/mspq_checker.sv
sim/tb_multilevel_sweep_priority_queue.sv
